// ===== hw/rtl/mbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// mbcm_pkg
// Shared types and constants of the masked band column mean block.
// ----------------------------------------------------------------------------
package mbcm_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MaxBand   = 128;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = $clog2(MaxHeight);
  localparam int unsigned WRegW = 11;
  localparam int unsigned HRegW = 13;
  localparam int unsigned CRegW = 12;
  localparam int unsigned TRegW = 8;
  localparam int unsigned MRegW = 2;
  localparam int unsigned SmpW  = 32;
  localparam int unsigned CntW  = 8;
  localparam int unsigned SumW  = SmpW + $clog2(MaxBand);
  localparam int unsigned IdxW  = 3;
  localparam int unsigned CfgW  = 13;

  localparam logic [IdxW-1:0] RegWidth  = 3'd0;
  localparam logic [IdxW-1:0] RegHeight = 3'd1;
  localparam logic [IdxW-1:0] RegCenter = 3'd2;
  localparam logic [IdxW-1:0] RegThick  = 3'd3;
  localparam logic [IdxW-1:0] RegMode   = 3'd4;

  localparam logic [MRegW-1:0] ModeAll      = 2'd0;
  localparam logic [MRegW-1:0] ModeMasked   = 2'd1;
  localparam logic [MRegW-1:0] ModeUnmasked = 2'd2;

  typedef struct packed {
    logic [WRegW-1:0] width;
    logic [HRegW-1:0] height;
    logic [RowW-1:0]  first_row;
    logic [RowW-1:0]  last_row;
    logic [MRegW-1:0] mode;
  } band_cfg_t;

  typedef struct packed {
    logic [ColW-1:0]        column;
    logic signed [SumW-1:0] sum;
    logic [CntW-1:0]        count;
  } emit_t;

endpackage

// ===== hw/rtl/mbcm_front.sv =====
// ----------------------------------------------------------------------------
// mbcm_front
// Tracks the raster position, classifies pixels and accumulates column sums.
// ----------------------------------------------------------------------------
module mbcm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mbcm_pkg::band_cfg_t             cfg_i,
  input  logic                            push,
  output logic                            full,
  input  logic signed [mbcm_pkg::SmpW-1:0] sample_i,
  input  logic                            mask_set_i,
  input  logic                            frame_start_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output mbcm_pkg::emit_t                 q_data_o
);

  typedef enum logic {StAccept, StUpdate} state_e;

  localparam int unsigned MemW = mbcm_pkg::SumW + mbcm_pkg::CntW;

  state_e                           state_q;
  logic [mbcm_pkg::ColW-1:0]        col_q, row_col_q;
  logic [mbcm_pkg::RowW-1:0]        row_q;
  logic                             in_band_q, first_q, last_q, use_q;
  logic signed [mbcm_pkg::SmpW-1:0] smp_q;
  logic [MemW-1:0]                  mem_q [mbcm_pkg::MaxWidth];
  logic [MemW-1:0]                  rdata_q;

  logic                      accept;
  logic [mbcm_pkg::ColW-1:0] col_c;
  logic [mbcm_pkg::RowW-1:0] row_c;
  logic [mbcm_pkg::WRegW-1:0] col_inc;
  logic [mbcm_pkg::HRegW-1:0] row_inc;
  logic                      use_c;
  logic signed [mbcm_pkg::SumW-1:0] sum_new;
  logic [mbcm_pkg::CntW-1:0]        cnt_new;

  assign full   = (state_q != StAccept) || q_full_i;
  assign accept = push && !full;

  always_comb begin
    col_c = frame_start_i ? '0 : col_q;
    row_c = frame_start_i ? '0 : row_q;
    if ({1'b0, col_c} >= cfg_i.width) col_c = '0;
    if ({1'b0, row_c} >= cfg_i.height) row_c = '0;
    col_inc = {1'b0, col_c} + 1'b1;
    row_inc = {1'b0, row_c} + 1'b1;
    unique case (cfg_i.mode)
      mbcm_pkg::ModeMasked:   use_c = mask_set_i;
      mbcm_pkg::ModeUnmasked: use_c = !mask_set_i;
      default:                use_c = 1'b1;
    endcase
  end

  always_comb begin
    sum_new = first_q ? '0 : $signed(rdata_q[MemW-1:mbcm_pkg::CntW]);
    cnt_new = first_q ? '0 : rdata_q[mbcm_pkg::CntW-1:0];
    if (use_q) begin
      sum_new = sum_new + mbcm_pkg::SumW'(smp_q);
      cnt_new = cnt_new + 1'b1;
    end
  end

  assign q_push_o = (state_q == StUpdate) && in_band_q && last_q && (cnt_new != '0);
  assign q_data_o = '{column: row_col_q, sum: sum_new, count: cnt_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAccept;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      unique case (state_q)
        StAccept: begin
          if (accept) begin
            state_q <= StUpdate;
            if (col_inc >= cfg_i.width) begin
              col_q <= '0;
              row_q <= (row_inc >= cfg_i.height) ? '0 : row_inc[mbcm_pkg::RowW-1:0];
            end else begin
              col_q <= col_inc[mbcm_pkg::ColW-1:0];
              row_q <= row_c;
            end
          end
        end
        StUpdate: state_q <= StAccept;
        default:  state_q <= StAccept;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_col_q <= col_c;
      smp_q     <= sample_i;
      use_q     <= use_c;
      in_band_q <= (row_c >= cfg_i.first_row) && (row_c <= cfg_i.last_row);
      first_q   <= row_c == cfg_i.first_row;
      last_q    <= row_c == cfg_i.last_row;
      rdata_q   <= mem_q[col_c];
    end
    if (state_q == StUpdate && in_band_q) begin
      mem_q[row_col_q] <= {sum_new, cnt_new};
    end
  end

endmodule

// ===== hw/rtl/mbcm_fifo.sv =====
// ----------------------------------------------------------------------------
// mbcm_fifo
// Two-entry queue of emit jobs between the front and the divider.
// ----------------------------------------------------------------------------
module mbcm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbcm_pkg::emit_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mbcm_pkg::emit_t data_o
);

  mbcm_pkg::emit_t ent_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wptr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/mbcm_div.sv =====
// ----------------------------------------------------------------------------
// mbcm_div
// Bit-serial signed divide of a column sum by its count, with result register.
// ----------------------------------------------------------------------------
module mbcm_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  mbcm_pkg::emit_t                  q_data_i,
  output logic                             q_pop_o,
  output logic                             empty,
  input  logic                             pop,
  output logic [mbcm_pkg::ColW-1:0]        column_o,
  output logic signed [mbcm_pkg::SmpW-1:0] mean_value_o,
  output logic [mbcm_pkg::CntW-1:0]        samples_used_o
);

  typedef enum logic [1:0] {StIdle, StRun, StDone} state_e;

  localparam int unsigned SumW  = mbcm_pkg::SumW;
  localparam int unsigned CntW  = mbcm_pkg::CntW;
  localparam int unsigned StepW = $clog2(SumW + 1);

  state_e                    state_q;
  logic [StepW-1:0]          step_q;
  logic [SumW-1:0]           quo_q;
  logic [CntW-1:0]           rem_q, div_q;
  logic                      neg_q;
  logic [mbcm_pkg::ColW-1:0] col_q;
  logic                      out_valid_q;
  logic                      out_valid_d;

  logic [CntW:0]   rem_sh;
  logic [CntW:0]   rem_sub;
  logic [SumW-1:0] mag;
  logic [SumW-1:0] res;

  assign q_pop_o = (state_q == StIdle) && !q_empty_i;
  assign empty   = !out_valid_q;
  assign mag     = q_data_i.sum[SumW-1] ? SumW'(-q_data_i.sum) : SumW'(q_data_i.sum);
  assign rem_sh  = {rem_q, quo_q[SumW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign res     = neg_q ? -quo_q : quo_q;

  always_comb begin
    out_valid_d = out_valid_q && !pop;
    if ((state_q == StDone) && (!out_valid_q || pop)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      out_valid_q    <= 1'b0;
      step_q         <= '0;
      quo_q          <= '0;
      rem_q          <= '0;
      div_q          <= '0;
      neg_q          <= 1'b0;
      col_q          <= '0;
      column_o       <= '0;
      mean_value_o   <= '0;
      samples_used_o <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        StIdle: begin
          if (!q_empty_i) begin
            state_q <= StRun;
            step_q  <= StepW'(SumW);
            quo_q   <= mag;
            rem_q   <= '0;
            div_q   <= q_data_i.count;
            neg_q   <= q_data_i.sum[SumW-1];
            col_q   <= q_data_i.column;
          end
        end
        StRun: begin
          if (rem_sub[CntW]) begin
            rem_q <= rem_sh[CntW-1:0];
            quo_q <= {quo_q[SumW-2:0], 1'b0};
          end else begin
            rem_q <= rem_sub[CntW-1:0];
            quo_q <= {quo_q[SumW-2:0], 1'b1};
          end
          step_q <= step_q - 1'b1;
          if (step_q == StepW'(1)) state_q <= StDone;
        end
        StDone: begin
          if (!out_valid_q || pop) begin
            state_q        <= StIdle;
            column_o       <= col_q;
            mean_value_o   <= res[mbcm_pkg::SmpW-1:0];
            samples_used_o <= div_q;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/masked_band_column_mean.sv =====
// ----------------------------------------------------------------------------
// masked_band_column_mean
// Per-column mean over a band of rows of a raster image, with pixel masking.
//
//   channel  direction  handshake           payload
//   pixel    in         push / full         sample_i, mask_set_i, frame_start_i
//   result   out        empty / pop         column_o, mean_value_o, samples_used_o
//   config   in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// In the front a pixel's column is read from the column memory, then written back;
// no new pixel is taken until the write. The serial divider loads a result, forms
// 39 quotient bits one a cycle, then outputs it; it takes no new one until then.
// A two-entry queue holds pending results and the front stalls when it fills.
// Reset clears position and control state; column memory needs no clearing.
// ----------------------------------------------------------------------------
module masked_band_column_mean (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbcm_pkg::IdxW-1:0]        cfg_idx_i,
  input  logic [mbcm_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic signed [mbcm_pkg::SmpW-1:0] sample_i,
  input  logic                             mask_set_i,
  input  logic                             frame_start_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [mbcm_pkg::ColW-1:0]        column_o,
  output logic signed [mbcm_pkg::SmpW-1:0] mean_value_o,
  output logic [mbcm_pkg::CntW-1:0]        samples_used_o
);

  logic [mbcm_pkg::WRegW-1:0] width_q;
  logic [mbcm_pkg::HRegW-1:0] height_q;
  logic [mbcm_pkg::CRegW-1:0] center_q;
  logic [mbcm_pkg::TRegW-1:0] thick_q;
  logic [mbcm_pkg::MRegW-1:0] mode_q;

  mbcm_pkg::band_cfg_t        cfg;
  logic [mbcm_pkg::WRegW-1:0] width_c;
  logic [mbcm_pkg::HRegW-1:0] height_c;
  logic [mbcm_pkg::TRegW-1:0] thick_c;
  logic [mbcm_pkg::RowW-1:0]  hmax, center_c, lo_off;
  logic [mbcm_pkg::HRegW-1:0] last_c;

  logic            q_push, q_full, q_pop, q_empty;
  mbcm_pkg::emit_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbcm_pkg::WRegW'(256);
      height_q <= mbcm_pkg::HRegW'(256);
      center_q <= mbcm_pkg::CRegW'(128);
      thick_q  <= mbcm_pkg::TRegW'(1);
      mode_q   <= mbcm_pkg::ModeAll;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mbcm_pkg::RegWidth:  width_q  <= cfg_data_i[mbcm_pkg::WRegW-1:0];
        mbcm_pkg::RegHeight: height_q <= cfg_data_i[mbcm_pkg::HRegW-1:0];
        mbcm_pkg::RegCenter: center_q <= cfg_data_i[mbcm_pkg::CRegW-1:0];
        mbcm_pkg::RegThick:  thick_q  <= cfg_data_i[mbcm_pkg::TRegW-1:0];
        mbcm_pkg::RegMode:   mode_q   <= cfg_data_i[mbcm_pkg::MRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_c  = (width_q == '0) ? mbcm_pkg::WRegW'(1) :
               (width_q > mbcm_pkg::WRegW'(mbcm_pkg::MaxWidth)) ?
               mbcm_pkg::WRegW'(mbcm_pkg::MaxWidth) : width_q;
    height_c = (height_q == '0) ? mbcm_pkg::HRegW'(1) :
               (height_q > mbcm_pkg::HRegW'(mbcm_pkg::MaxHeight)) ?
               mbcm_pkg::HRegW'(mbcm_pkg::MaxHeight) : height_q;
    thick_c  = (thick_q == '0) ? mbcm_pkg::TRegW'(1) :
               (thick_q > mbcm_pkg::TRegW'(mbcm_pkg::MaxBand)) ?
               mbcm_pkg::TRegW'(mbcm_pkg::MaxBand) : thick_q;
    hmax     = mbcm_pkg::RowW'(height_c - 1'b1);
    center_c = (center_q > hmax) ? hmax : center_q;
    lo_off   = mbcm_pkg::RowW'((thick_c - 1'b1) >> 1);
    last_c   = {1'b0, center_c} + mbcm_pkg::HRegW'(thick_c >> 1);
    cfg.width     = width_c;
    cfg.height    = height_c;
    cfg.first_row = (center_c >= lo_off) ? center_c - lo_off : '0;
    cfg.last_row  = (last_c > {1'b0, hmax}) ? hmax : last_c[mbcm_pkg::RowW-1:0];
    cfg.mode      = mode_q;
  end

  mbcm_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .push,
    .full,
    .sample_i,
    .mask_set_i,
    .frame_start_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  mbcm_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  mbcm_div u_div (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .empty,
    .pop,
    .column_o,
    .mean_value_o,
    .samples_used_o
  );

endmodule

// ===== test/masked_band_column_mean_tb.sv =====
// ----------------------------------------------------------------------------
// masked_band_column_mean_tb
// Self-checking bench for the masked band column mean block. Pixels are
// pushed in raster frames under a sweep of register settings. Each result
// popped is checked against a behavioral profile model kept in the bench.
// A short directed table comes first, then frames under fixed corner settings,
// then random frames under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module masked_band_column_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 64;

  typedef struct {
    logic [mbcm_pkg::ColW-1:0]        column;
    logic signed [mbcm_pkg::SmpW-1:0] mean;
    logic [mbcm_pkg::CntW-1:0]        used;
  } point_t;

  typedef struct {
    logic signed [mbcm_pkg::SmpW-1:0] sample;
    bit                               mask;
    bit                               fs;
    bit                               typed;
    point_t                           point;
  } pixel_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [mbcm_pkg::IdxW-1:0]        cfg_idx_i = '0;
  logic [mbcm_pkg::CfgW-1:0]        cfg_data_i = '0;
  logic                             push = 1'b0;
  logic                             full;
  logic signed [mbcm_pkg::SmpW-1:0] sample_i = '0;
  logic                             mask_set_i = 1'b0;
  logic                             frame_start_i = 1'b0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic [mbcm_pkg::ColW-1:0]        column_o;
  logic signed [mbcm_pkg::SmpW-1:0] mean_value_o;
  logic [mbcm_pkg::CntW-1:0]        samples_used_o;

  point_t profile_q[$];
  int     errors = 0;
  int     cycles = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     pixels_sent = 0;

  int     reg_w = 256, reg_h = 256, reg_c = 128, reg_t = 1, reg_m = 0;
  longint col_sum[mbcm_pkg::MaxWidth];
  int     col_cnt[mbcm_pkg::MaxWidth];
  int     row_pos = 0, col_pos = 0;

  masked_band_column_mean i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .sample_i, .mask_set_i, .frame_start_i,
    .empty, .pop, .column_o, .mean_value_o, .samples_used_o
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk_i) begin
    point_t p;
    if (rst_ni && pop && !empty) begin
      if (profile_q.size() == 0) begin
        $error("unexpected result column=%0d mean=%0d", column_o, mean_value_o);
        errors++;
      end else begin
        p = profile_q.pop_front();
        if (column_o !== p.column) begin
          $error("column exp %0d got %0d", p.column, column_o);
          errors++;
        end
        if (mean_value_o !== p.mean) begin
          $error("mean_value exp %0d got %0d", p.mean, mean_value_o);
          errors++;
        end
        if (samples_used_o !== p.used) begin
          $error("samples_used exp %0d got %0d", p.used, samples_used_o);
          errors++;
        end
      end
    end
  end

  function automatic int clip(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic profile_step(input logic signed [mbcm_pkg::SmpW-1:0] s, input bit m,
                              input bit fs, output bit hit, output point_t p);
    int w, h, t, cen, lo, first, last;
    bit take;
    w = clip(reg_w, mbcm_pkg::MaxWidth);
    h = clip(reg_h, mbcm_pkg::MaxHeight);
    t = clip(reg_t, mbcm_pkg::MaxBand);
    cen = (reg_c > h - 1) ? h - 1 : reg_c;
    lo = (t - 1) / 2;
    first = (cen >= lo) ? cen - lo : 0;
    last = cen + t / 2;
    if (last > h - 1) last = h - 1;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    if (reg_m == mbcm_pkg::ModeMasked) take = m;
    else if (reg_m == mbcm_pkg::ModeUnmasked) take = !m;
    else take = 1'b1;
    hit = 1'b0;
    if (row_pos >= first && row_pos <= last) begin
      if (row_pos == first) begin
        col_sum[col_pos] = 0;
        col_cnt[col_pos] = 0;
      end
      if (take) begin
        col_sum[col_pos] += longint'(s);
        col_cnt[col_pos]++;
      end
      if (row_pos == last && col_cnt[col_pos] != 0) begin
        hit = 1'b1;
        p.column = col_pos[mbcm_pkg::ColW-1:0];
        p.mean = mbcm_pkg::SmpW'(col_sum[col_pos] / longint'(col_cnt[col_pos]));
        p.used = col_cnt[col_pos][mbcm_pkg::CntW-1:0];
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_pixel(input pixel_row_t px);
    int gap;
    bit hit;
    point_t p;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    sample_i <= px.sample;
    mask_set_i <= px.mask;
    frame_start_i <= px.fs;
    forever begin
      @(negedge clk_i);
      if (!full) break;
      @(posedge clk_i);
    end
    profile_step(px.sample, px.mask, px.fs, hit, p);
    if (px.typed) profile_q.push_back(px.point);
    else if (hit) profile_q.push_back(p);
    pixels_sent++;
    @(posedge clk_i);
  endtask

  // Hold the sender until every result is out and the pipeline is quiet.
  task automatic drain();
    push <= 1'b0;
    while (profile_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mbcm_pkg::IdxW-1:0] idx, input int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= mbcm_pkg::CfgW'(value);
    case (idx)
      mbcm_pkg::RegWidth:  reg_w = value & 'h7FF;
      mbcm_pkg::RegHeight: reg_h = value & 'h1FFF;
      mbcm_pkg::RegCenter: reg_c = value & 'hFFF;
      mbcm_pkg::RegThick:  reg_t = value & 'hFF;
      mbcm_pkg::RegMode:   reg_m = value & 'h3;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int c, input int t, input int m);
    drain();
    write_reg(mbcm_pkg::RegWidth, w);
    write_reg(mbcm_pkg::RegHeight, h);
    write_reg(mbcm_pkg::RegCenter, c);
    write_reg(mbcm_pkg::RegThick, t);
    write_reg(mbcm_pkg::RegMode, m);
  endtask

  function automatic logic signed [mbcm_pkg::SmpW-1:0] pick_sample(int kind);
    if (kind == 1) return 32'sh7FFF_FFFF;
    if (kind == 2) return 32'sh8000_0000;
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_frame(input int n, input int kind, input bit noisy);
    pixel_row_t px;
    for (int i = 0; i < n; i++) begin
      px.sample = pick_sample(kind);
      px.mask = $urandom_range(1);
      px.fs = (i == 0) || (noisy && $urandom_range(99) < 2);
      px.typed = 1'b0;
      send_pixel(px);
    end
  endtask

  pixel_row_t directed[$];

  initial begin
    int w, h;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(4, 3, 0, 1, mbcm_pkg::ModeAll);
    directed.push_back('{32'sh7FFF_FFFF, 0, 1, 1, '{0, 32'sh7FFF_FFFF, 1}});
    directed.push_back('{32'sh8000_0000, 1, 0, 1, '{1, 32'sh8000_0000, 1}});
    directed.push_back('{32'sh0, 0, 0, 1, '{2, 32'sh0, 1}});
    directed.push_back('{-32'sd1, 1, 0, 1, '{3, -32'sd1, 1}});
    for (int i = 0; i < 8; i++)
      directed.push_back('{$urandom, $urandom_range(1), 0, 0, '{0, 0, 0}});
    directed.push_back('{32'sh1234_5678, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{32'sh0001_0000, 1, 1, 1, '{0, 32'sh0001_0000, 1}});
    foreach (directed[i]) send_pixel(directed[i]);

    configure(3, 5, 2, 4, mbcm_pkg::ModeMasked);
    run_frame(15, 0, 0);
    configure(3, 5, 2, 4, mbcm_pkg::ModeUnmasked);
    run_frame(15, 0, 0);
    configure(1, 130, 64, 255, 3);
    run_frame(130, 1, 0);
    configure(1, 130, 64, 128, mbcm_pkg::ModeAll);
    run_frame(130, 2, 0);
    configure(3, 0, 7, 0, mbcm_pkg::ModeAll);
    run_frame(6, 0, 0);
    configure(2047, 1, 0, 1, mbcm_pkg::ModeAll);
    run_frame(12, 0, 0);
    configure(5, 8191, 4095, 2, mbcm_pkg::ModeAll);
    run_frame(20, 0, 0);

    for (int phase = 0; (phase < 4) || (pixels_sent < 1100); phase++) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      configure(w, h, $urandom_range(0, h + 2), $urandom_range(0, h + 2), $urandom_range(3));
      case (phase % 5)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(9) == 0) run_frame($urandom_range(1, w * h), 0, 1);
        else run_frame(w * h, 0, 1);
      end
    end

    drain();
    if (profile_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
